>>> rtl/core/in_order_release_buffer_macros.svh
// Assertion macros for the in-order release buffer checker.
// No dependencies; included by the checker file only.
`ifndef IN_ORDER_RELEASE_BUFFER_MACROS_SVH
`define IN_ORDER_RELEASE_BUFFER_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define IORB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define IORB_ASSERT_RST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/iorb_pkg.sv
// Shared widths, register indexes and interface structs for the in-order release buffer.
// No dependencies.
package iorb_pkg;

   // fixed field widths
   localparam int ID_W       = 7;
   localparam int DATA_W     = 32;
   localparam int LEN_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] LENGTH_RESET = 7'd64;

   // register index, taken from paddr[2]
   localparam logic REG_STREAM_LENGTH = 1'b0;

   // value store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } iorb_mem_ctl_type;

   // release beat toward the output register
   typedef struct packed {
      logic load;
      logic last;
   } iorb_rel_type;

endpackage

>>> rtl/core/iorb_store.sv
// Value store: one write port, one read port with a registered read.
// No package dependency beyond the control struct in iorb_pkg.
module iorb_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  iorb_pkg::iorb_mem_ctl_type  mem_ctl,
   input  logic [AW-1:0]               wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] value_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         value_mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= value_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/iorb_seq.sv
// Insert and release sequencer: present bits, release pointer, store port control.
// Depends on iorb_pkg.
module iorb_seq #(
   parameter int MAX_IDS = 64,
   localparam int IDX_W = $clog2(MAX_IDS),
   localparam int PTR_W = $clog2(MAX_IDS + 2)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [iorb_pkg::ID_W-1:0]     req_item_id,
   output logic                          req_stall,
   input  logic [iorb_pkg::LEN_W-1:0]    stream_len,
   input  logic                          out_free,
   output iorb_pkg::iorb_mem_ctl_type    mem_ctl,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [IDX_W-1:0]              rd_addr,
   output iorb_pkg::iorb_rel_type        rel,
   output logic [iorb_pkg::ID_W-1:0]     rel_id
);
   import iorb_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   localparam logic [ID_W-1:0] LEN_MAX = ID_W'(MAX_IDS);

   logic [1:0]         state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               last_ff, last_in;
   logic [MAX_IDS-1:0] present_ff, present_in;

   logic [ID_W-1:0]  len_eff;
   logic [ID_W-1:0]  id_m1;
   logic [ID_W-1:0]  ptr_ext;
   logic [PTR_W-1:0] ptr_m1;
   logic [IDX_W-1:0] id_idx;
   logic [IDX_W-1:0] ptr_idx;
   logic             id_ok;
   logic             insert;
   logic             ptr_hit;
   logic             run_last;

   // clamp the configured length into 1..MAX_IDS
   always_comb begin
      priority if (stream_len == '0) begin
         len_eff = ID_W'(1);
      end else if (stream_len > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = stream_len;
      end
   end

   // insert decode
   assign id_m1   = req_item_id - ID_W'(1);
   assign id_idx  = id_m1[IDX_W-1:0];
   assign id_ok   = (req_item_id != '0) && (req_item_id <= len_eff);
   assign req_stall = (state_ff != ST_IDLE);
   assign insert  = req_valid && !req_stall && id_ok && !present_ff[id_idx];

   // pointer checks; next entry is at 0-based index ptr - 1
   assign ptr_ext  = ID_W'(ptr_ff);
   assign ptr_m1   = ptr_ff - PTR_W'(1);
   assign ptr_idx  = ptr_m1[IDX_W-1:0];
   assign ptr_hit  = (ptr_ext <= len_eff) && present_ff[ptr_idx];
   assign run_last = !((ptr_ext < len_eff) && present_ff[ptr_ff[IDX_W-1:0]]);

   assign wr_addr = id_idx;
   assign rd_addr = ptr_idx;
   assign rel_id  = ptr_ext;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      present_in = present_ff;
      mem_ctl    = '0;
      rel        = '0;
      mem_ctl.wr_en = insert;
      if (insert) begin
         present_in[id_idx] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (insert) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (!ptr_hit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               mem_ctl.rd_en = 1'b1;
               last_in       = run_last;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // read data is back: hand the beat to the output register
            rel.load = 1'b1;
            rel.last = last_ff;
            ptr_in   = ptr_ff + PTR_W'(1);
            state_in = last_ff ? ST_IDLE : ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ptr_ff     <= PTR_W'(1);
         present_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         present_ff <= present_in;
      end
   end

   // run end flag, payload
   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

endmodule

>>> rtl/core/in_order_release_buffer.sv
// Top level of the in-order release buffer: config register, output register, sequencer, store.
// Depends on iorb_pkg, iorb_seq and iorb_store.
//
//   channel  | direction | handshake        | beat
//   req      | in        | valid / stall    | item_id, item_value
//   rsp      | out       | valid / stall    | out_value, out_id, run_last
//   csr      | in / out  | APB, pready = 1  | stream_length at byte 0
//
// An item is taken while req is not stalled; a stored one then costs a check, or, when it
// completes a run, a check with store read and then a load for each released value.
// req is stalled from the cycle after an insert until the run has been handed over.
// A full output register holds the store read until it is taken.
// Reset is synchronous: present bits clear at once, pointer to 1, length to 64;
// the value store is not cleared.
module in_order_release_buffer #(
   parameter int MAX_IDS     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [iorb_pkg::ID_W-1:0]         req_item_id,
   input  logic [iorb_pkg::DATA_W-1:0]       req_item_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [iorb_pkg::DATA_W-1:0]       rsp_out_value,
   output logic [iorb_pkg::ID_W-1:0]         rsp_out_id,
   output logic                              rsp_run_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [iorb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iorb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iorb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import iorb_pkg::*;

   localparam int IDX_W   = $clog2(MAX_IDS);
   localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              csr_index;
   logic              csr_wr;
   logic              out_free;
   iorb_mem_ctl_type  mem_ctl;
   iorb_rel_type      rel;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic [ID_W-1:0]   rel_id;
   logic [STORE_W-1:0] rd_data;

   // config register
   assign csr_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign len_in     = (csr_wr && csr_index == REG_STREAM_LENGTH) ?
                       csr_pwdata[LEN_W-1:0] : len_ff;
   assign csr_prdata = (csr_index == REG_STREAM_LENGTH) ? CSR_DATA_W'(len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LENGTH_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      if (rel.load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = DATA_W'(rd_data);
         rsp_id_in    = rel_id;
         rsp_last_in  = rel.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_run_last  = rsp_last_ff;

   // sequencer
   iorb_seq #(
      .MAX_IDS (MAX_IDS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item_id (req_item_id),
      .req_stall   (req_stall),
      .stream_len  (len_ff),
      .out_free    (out_free),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .rel         (rel),
      .rel_id      (rel_id)
   );

   // value store
   iorb_store #(
      .DEPTH (MAX_IDS),
      .WIDTH (STORE_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (req_item_value[STORE_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> rtl/core/iorb_checker.sv
// Port-level checker for the in-order release buffer, bound to the top level.
// Depends on iorb_pkg and in_order_release_buffer_macros.svh.
`include "in_order_release_buffer_macros.svh"

module iorb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [iorb_pkg::DATA_W-1:0]   rsp_out_value,
   input logic [iorb_pkg::ID_W-1:0]     rsp_out_id,
   input logic                          rsp_run_last
);

   // a stalled result beat holds
   `IORB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_id) && $stable(rsp_run_last), "stalled rsp beat changed")

   // no new item while a run is still being released
   `IORB_ASSERT(a_run_blocks_req, clock, reset, rsp_valid && !rsp_run_last |-> req_stall, "req taken during a run")

   // released ids start at one
   `IORB_ASSERT(a_id_nonzero, clock, reset, rsp_valid |-> rsp_out_id != '0, "released id is zero")

   // each mid-run beat is followed by a store read cycle
   `IORB_ASSERT(a_run_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_run_last |=> !rsp_valid, "mid-run beat not followed by read cycle")

   // reset empties the output register
   `IORB_ASSERT_RST(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind in_order_release_buffer iorb_checker u_iorb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_out_id    (rsp_out_id),
   .rsp_run_last  (rsp_run_last)
);

>>> sim/iorb_release_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the in-order release buffer: follows the stream length through the csr
// port, predicts the released values for each accepted req beat and checks every rsp beat.
// Depends on iorb_pkg.
module iorb_release_checker #(
   parameter int MAX_IDS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [iorb_pkg::ID_W-1:0]       req_item_id,
   input  logic [iorb_pkg::DATA_W-1:0]     req_item_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [iorb_pkg::DATA_W-1:0]     rsp_out_value,
   input  logic [iorb_pkg::ID_W-1:0]       rsp_out_id,
   input  logic                            rsp_run_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [iorb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [iorb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              outstanding,
   output int                              items_taken,
   output int                              values_released
);
   import iorb_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [ID_W-1:0]   id;
      logic              last;
   } release_beat_type;

   // shadow of the block state
   logic [DATA_W-1:0] stored_value [1:MAX_IDS];
   bit                present      [1:MAX_IDS];
   logic [ID_W-1:0]   next_release;
   logic [LEN_W-1:0]  length_reg;
   release_beat_type  release_q [$];

   // written length clamped into 1..MAX_IDS
   function automatic int clamp_length(input logic [LEN_W-1:0] raw);
      if (raw < 1) return 1;
      if (raw > MAX_IDS) return MAX_IDS;
      return int'(raw);
   endfunction

   // store one item and queue the run it completes, if any
   task automatic predict_insert(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] value);
      int               len;
      release_beat_type beat;
      len = clamp_length(length_reg);
      if (id < 1 || id > len || present[id]) return;
      stored_value[id] = value;
      present[id] = 1'b1;
      while (next_release <= len && present[next_release]) begin
         beat.value = stored_value[next_release];
         beat.id = next_release;
         next_release++;
         beat.last = !(next_release <= len && present[next_release]);
         release_q.insert(release_q.size(), beat);
      end
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // rsp check first (it belongs to older items), then req, then csr
   always @(posedge clock) begin
      release_beat_type want;
      if (reset) begin
         foreach (present[i]) present[i] = 1'b0;
         next_release = 1;
         length_reg = LENGTH_RESET;
         release_q.delete();
         mismatch_count = 0;
         items_taken = 0;
         values_released = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            values_released++;
            if (release_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat, expected none, got id %0d value %0h last %b",
                        $time, rsp_out_id, rsp_out_value, rsp_run_last);
            end else begin
               want = release_q.pop_front();
               compare_field("out_value", want.value, rsp_out_value);
               compare_field("out_id", DATA_W'(want.id), DATA_W'(rsp_out_id));
               compare_field("run_last", DATA_W'(want.last), DATA_W'(rsp_run_last));
            end
         end
         if (req_valid && !req_stall) begin
            items_taken++;
            predict_insert(req_item_id, req_item_value);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_STREAM_LENGTH)
            length_reg = csr_pwdata[LEN_W-1:0];
      end
      outstanding = release_q.size();
   end

endmodule

>>> sim/tb_in_order_release_buffer.sv
`timescale 1ns / 100ps
// Testbench top for the in-order release buffer: clock, reset, req/rsp/csr stimulus, verdict.
// Depends on iorb_pkg, in_order_release_buffer and iorb_release_checker.
module tb_in_order_release_buffer;
   import iorb_pkg::*;

   localparam int MAX_IDS      = 64;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 300;
   localparam int CHUNK_ITEMS  = 45;
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR = {REG_STREAM_LENGTH, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ID_W-1:0]       req_item_id;
   logic [DATA_W-1:0]     req_item_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DATA_W-1:0]     rsp_out_value;
   logic [ID_W-1:0]       rsp_out_id;
   logic                  rsp_run_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int outstanding;
   int items_taken;
   int values_released;

   // stimulus bookkeeping
   bit              steady;
   bit              hold_off_req;
   int              cur_len;
   bit              is_stored [1:MAX_IDS];
   logic [ID_W-1:0] stored_ids [$];
   logic [ID_W-1:0] fresh_ids [$];

   in_order_release_buffer #(.MAX_IDS(MAX_IDS), .VALUE_WIDTH(DATA_W)) u_top (.*);

   iorb_release_checker #(.MAX_IDS(MAX_IDS)) u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end

   // rsp side: random stalls, or a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_left = LONG_HOLD;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else
            rsp_stall <= !steady && ($urandom_range(99) < 10);
      end
   end

   // one req beat, with a random gap in front; returns at the negedge after acceptance
   task automatic send_item(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] value);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < 10) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item_id <= id;
      req_item_value <= value;
      do @(posedge clock); while (req_stall);
      if (id >= 1 && id <= cur_len && !is_stored[id]) begin
         is_stored[id] = 1'b1;
         stored_ids.insert(stored_ids.size(), id);
      end
      @(negedge clock);
   endtask

   // stop sending and wait for every expected value, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_len = (len < 1) ? 1 : (len > MAX_IDS) ? MAX_IDS : int'(len);
   endtask

   initial begin
      int              chunk;
      int              sent;
      int              eligible;
      int              pick;
      logic [ID_W-1:0] id;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item_id = '0;
      req_item_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady = 1'b0;
      hold_off_req = 1'b0;
      cur_len = MAX_IDS;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // length zero acts as one: out-of-range drops, single release, repeat drop
      write_length(0);
      send_item(0, '0);
      send_item(127, '1);
      send_item(2, $urandom);
      send_item(1, '1);
      send_item(1, '0);
      drain();

      // ahead arrivals, then one run of four under a long rsp hold-off
      write_length(5);
      send_item(5, '0);
      send_item(3, $urandom);
      send_item(4, $urandom);
      hold_off_req = 1'b1;
      send_item(2, $urandom);
      send_item(6, $urandom);
      send_item(3, $urandom);
      drain();

      write_length(10);
      send_item(8, $urandom);
      send_item(7, $urandom);
      send_item(6, $urandom);
      send_item(10, $urandom);
      drain();

      // shorter length stops the run before the stored id 10
      write_length(9);
      send_item(9, $urandom);
      send_item(10, $urandom);
      drain();

      // clamped length; id 10 waiting at the pointer goes out with 11
      write_length(127);
      send_item(11, $urandom);
      send_item(65, $urandom);
      send_item(64, $urandom);
      drain();

      for (int i = 12; i < MAX_IDS; i++) fresh_ids.insert(fresh_ids.size(), ID_W'(i));

      // random chunks: mostly near-ordered fresh ids, the rest repeats and out-of-range ids
      for (chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0: write_length(LEN_W'(MAX_IDS));
            1: write_length(LEN_W'($urandom_range(0, 127)));
            2: write_length(LEN_W'($urandom_range(MAX_IDS, 127)));
            default: write_length(LEN_W'(MAX_IDS));
         endcase
         steady = (chunk == 1);
         sent = 0;
         while (sent < CHUNK_ITEMS || (chunk == 3 && fresh_ids.size() > 0)) begin
            eligible = 0;
            while (eligible < fresh_ids.size() && fresh_ids[eligible] <= cur_len) eligible++;
            if (eligible > 0 && $urandom_range(99) < 65) begin
               pick = $urandom_range(0, ((eligible < 4) ? eligible : 4) - 1);
               id = fresh_ids[pick];
               fresh_ids.delete(pick);
            end else if ($urandom_range(1) == 0)
               id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
            else if (cur_len < 127 && $urandom_range(1) == 1)
               id = ID_W'($urandom_range(cur_len + 1, 127));
            else
               id = '0;
            send_item(id, $urandom);
            sent++;
         end
         drain();
      end
      steady = 1'b0;

      $display("Run took %0d items, repeats and out-of-range ids among them, and checked", items_taken);
      $display("%0d released values under lengths zero, 5, 9, 10, random, clamped and 64.",
               values_released);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/iorb_pkg.sv
rtl/core/iorb_store.sv
rtl/core/iorb_seq.sv
rtl/core/in_order_release_buffer.sv
rtl/core/iorb_checker.sv
sim/iorb_release_checker.sv
sim/tb_in_order_release_buffer.sv
